/* hdl/mrp_pkg.sv */
// ----------------------------------------------------------------------------
// mrp_pkg: shared types, constants and rule table of the maze path reducer
// Move codes, stack sizing, the queue word between front and back, the
// back-end sequencer states and the x,B,y reduction rule lookup.
// ----------------------------------------------------------------------------
package mrp_pkg;

	// stack capacity and derived widths
	localparam int CAP    = 128;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int ADDR_W = $clog2(CAP);

	// front-to-back queue depth
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// move codes
	localparam logic [1:0] MV_L = 2'd0;
	localparam logic [1:0] MV_S = 2'd1;
	localparam logic [1:0] MV_R = 2'd2;
	localparam logic [1:0] MV_B = 2'd3;

	// word passed from front to back
	typedef struct packed {
		logic       replay;
		logic [1:0] move;
	} op_t;

	// outcome of a rule lookup
	typedef struct packed {
		logic       hit;
		logic [1:0] move;
	} rule_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MID,
		ST_FIRST,
		ST_RP,
		ST_EMIT
	} st_t;

	// look up the replacement for the triple first,B,last
	function automatic rule_t rule_lookup(logic [1:0] first, logic [1:0] last);
		rule_t r;
		r.hit  = 1'b1;
		r.move = MV_L;
		unique case ({first, last})
			{MV_L, MV_L}: r.move = MV_S;
			{MV_L, MV_S}: r.move = MV_R;
			{MV_L, MV_R}: r.move = MV_B;
			{MV_S, MV_L}: r.move = MV_R;
			{MV_S, MV_S}: r.move = MV_B;
			{MV_S, MV_R}: r.move = MV_L;
			{MV_R, MV_L}: r.move = MV_B;
			{MV_R, MV_S}: r.move = MV_L;
			default:      r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* hdl/mrp_if.sv */
// ----------------------------------------------------------------------------
// mrp_if: handshake channels of the maze path reducer
// Move input channel, result output channel and configuration write channel,
// each with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface mrp_move_if;
	logic       valid;
	logic       ready;
	logic [1:0] move_in;

	modport source (output valid, output move_in, input ready);
	modport sink   (input valid, input move_in, output ready);
endinterface

interface mrp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] move_out;
	logic       move_valid;
	logic [7:0] stored_count;
	logic       dropped;

	modport source (output valid, output move_out, output move_valid,
		output stored_count, output dropped, input ready);
	modport sink   (input valid, input move_out, input move_valid,
		input stored_count, input dropped, output ready);
endinterface

interface mrp_cfg_if;
	logic valid;
	logic ready;
	logic replay_mode;

	modport source (output valid, output replay_mode, input ready);
	modport sink   (input valid, input replay_mode, output ready);
endinterface

/* hdl/mrp_ram.sv */
// ----------------------------------------------------------------------------
// mrp_ram: generic single-write, single-read RAM
// One write port and one read port per cycle; read data is registered.
// ----------------------------------------------------------------------------
module mrp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/mrp_front.sv */
// ----------------------------------------------------------------------------
// mrp_front: input side of the maze path reducer
// Holds the mode register, accepts move words, tags each as record or replay
// and hands it to the queue. Signals a replay rewind on every mode write.
// ----------------------------------------------------------------------------
module mrp_front
	import mrp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	mrp_move_if.sink       moves,
	mrp_cfg_if.sink        cfg,
	output logic           q_push,
	output op_t            q_wdata,
	input  logic           q_ready,
	output logic           rewind
);

	logic mode_q;

	// configuration always taken
	assign cfg.ready = 1'b1;
	assign rewind    = cfg.valid;

	// hold mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg.valid) begin
			mode_q <= cfg.replay_mode;
		end
	end

	// classify and forward accepted words
	assign moves.ready    = q_ready;
	assign q_push         = moves.valid & q_ready;
	assign q_wdata.replay = mode_q;
	assign q_wdata.move   = moves.move_in;

endmodule

/* hdl/mrp_queue.sv */
// ----------------------------------------------------------------------------
// mrp_queue: short word queue between front and back
// Register FIFO of QDEPTH words; push and pop may coincide.
// ----------------------------------------------------------------------------
module mrp_queue
	import mrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  wdata,
	output logic ready,
	input  logic pop,
	output logic valid,
	output op_t  rdata
);

	op_t               slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign ready   = fill_q < QCNT_W'(QDEPTH);
	assign valid   = fill_q != '0;
	assign rdata   = slot_q[rd_ptr_q];
	assign do_push = push & ready;
	assign do_pop  = pop & valid;

	// store pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/mrp_back.sv */
// ----------------------------------------------------------------------------
// mrp_back: execution side of the maze path reducer
// Sequencer over the move stack RAM: pushes recorded moves, folds x,B,y
// triples one rule per pass, reads replayed moves, and holds the result
// word in an output register.
// ----------------------------------------------------------------------------
module mrp_back
	import mrp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  op_t           q_rdata,
	output logic          q_pop,
	input  logic          rewind,
	mrp_result_if.source  results
);

	st_t               state_q;
	st_t               state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  rp_idx_q;
	logic [1:0]        top_q;
	logic [1:0]        res_move_q;
	logic              res_valid_q;
	logic              res_drop_q;
	logic              out_valid_q;
	logic [1:0]        out_move_q;
	logic              out_mvalid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_drop_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [1:0]        mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [1:0]        mem_rdata;

	logic              full;
	logic              has_next;
	logic              out_free;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic [CNT_W-1:0]  cnt_m1;
	logic [CNT_W-1:0]  cnt_m3;
	logic [CNT_W-1:0]  cnt_m4;
	rule_t             rule;

	mrp_ram #(
		.WIDTH (2),
		.DEPTH (CAP)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// stack arithmetic and rule lookup
	assign full     = ({1'b0, cnt_q} + (CNT_W + 1)'(2)) >= (CNT_W + 1)'(CAP);
	assign has_next = rp_idx_q < cnt_q;
	assign out_free = !out_valid_q || results.ready;
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign cnt_dec  = cnt_q - CNT_W'(2);
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign cnt_m3   = cnt_q - CNT_W'(3);
	assign cnt_m4   = cnt_q - CNT_W'(4);
	assign rule     = rule_lookup(mem_rdata, top_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_rdata.replay) begin
						state_d = has_next ? ST_RP : ST_EMIT;
					end else if (full) begin
						state_d = ST_EMIT;
					end else begin
						state_d = (cnt_inc >= CNT_W'(3)) ? ST_MID : ST_EMIT;
					end
				end
			end
			ST_MID: begin
				state_d = (mem_rdata == MV_B) ? ST_FIRST : ST_EMIT;
			end
			ST_FIRST: begin
				if (rule.hit && cnt_dec >= CNT_W'(3)) begin
					state_d = ST_MID;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_RP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = out_free ? ST_IDLE : ST_EMIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory and queue controls
	always_comb begin
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cnt_q[ADDR_W-1:0];
		mem_wdata = q_rdata.move;
		mem_re    = 1'b0;
		mem_raddr = cnt_m1[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					if (q_rdata.replay) begin
						mem_re    = has_next;
						mem_raddr = rp_idx_q[ADDR_W-1:0];
					end else if (!full) begin
						mem_we    = 1'b1;
						mem_re    = cnt_inc >= CNT_W'(3);
						mem_raddr = cnt_m1[ADDR_W-1:0];
					end
				end
			end
			ST_MID: begin
				mem_re    = mem_rdata == MV_B;
				mem_raddr = cnt_m3[ADDR_W-1:0];
			end
			ST_FIRST: begin
				mem_we    = rule.hit;
				mem_waddr = cnt_m3[ADDR_W-1:0];
				mem_wdata = rule.move;
				mem_re    = rule.hit && cnt_dec >= CNT_W'(3);
				mem_raddr = cnt_m4[ADDR_W-1:0];
			end
			ST_RP, ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer and stack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rp_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (rewind) begin
				rp_idx_q <= '0;
			end else if (state_q == ST_IDLE && q_valid && q_rdata.replay && has_next) begin
				rp_idx_q <= rp_idx_q + CNT_W'(1);
			end
			if (state_q == ST_IDLE && q_valid && !q_rdata.replay && !full) begin
				cnt_q <= cnt_inc;
			end else if (state_q == ST_FIRST && rule.hit) begin
				cnt_q <= cnt_dec;
			end
		end
	end

	// hold top of stack and the word under construction
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			res_move_q  <= MV_L;
			res_valid_q <= q_rdata.replay & has_next;
			res_drop_q  <= !q_rdata.replay & full;
			if (!q_rdata.replay) begin
				top_q <= q_rdata.move;
			end
		end
		if (state_q == ST_FIRST && rule.hit) begin
			top_q <= rule.move;
		end
		if (state_q == ST_RP) begin
			res_move_q <= mem_rdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_move_q   <= res_move_q;
			out_mvalid_q <= res_valid_q;
			out_count_q  <= cnt_q;
			out_drop_q   <= res_drop_q;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.move_out     = out_move_q;
	assign results.move_valid   = out_mvalid_q;
	assign results.stored_count = 8'(out_count_q);
	assign results.dropped      = out_drop_q;

endmodule

/* hdl/maze_path_reducer_top.sv */
// ----------------------------------------------------------------------------
// maze_path_reducer_top: turn-move stack with path simplification
// Records left/straight/right/back moves, folds dead-end triples on the fly
// and replays the simplified path on request.
// ----------------------------------------------------------------------------
// Usage:
//   moves   : one move word per item (move_in); in replay mode the value is
//             ignored and the item just asks for the next stored move.
//   results : one word per accepted move: move_out, move_valid,
//             stored_count, dropped.
//   cfg     : writes replay_mode; every write rewinds the replay position.
//             Write only while no item is in flight.
// Sequencing: a dropped push or an exhausted replay passes from ST_IDLE
//   to ST_EMIT and the output register, a replayed move through ST_RP. A
//   push with three or more moves stored visits ST_MID to read the move
//   under it, ST_FIRST when that is a back, and ST_MID again after each
//   fold, since each fold needs two reads of the single-read stack RAM.
//   The sequencer takes the next item only once it is back in ST_IDLE.
// A two-word queue lets moves be taken while the sequencer is busy, and the
//   output register lets a new item start while a result waits.
// Reset empties the stack, clears the replay position and selects record
//   mode. The stack RAM needs no clearing pass. If results.ready stays low
//   the sequencer holds its finished word and the queue fills, then
//   moves.ready drops.
// ----------------------------------------------------------------------------
module maze_path_reducer_top
	import mrp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	mrp_move_if.sink     moves,
	mrp_result_if.source results,
	mrp_cfg_if.sink      cfg
);

	logic q_push;
	op_t  q_wdata;
	logic q_ready;
	logic q_pop;
	logic q_valid;
	op_t  q_rdata;
	logic rewind;

	// accept and classify
	mrp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.moves   (moves),
		.cfg     (cfg),
		.q_push  (q_push),
		.q_wdata (q_wdata),
		.q_ready (q_ready),
		.rewind  (rewind)
	);

	// decouple front from back
	mrp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.ready  (q_ready),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// execute on the stack
	mrp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_rdata (q_rdata),
		.q_pop   (q_pop),
		.rewind  (rewind),
		.results (results)
	);

endmodule

/* test/tb_maze_path_reducer_top.sv */
// ----------------------------------------------------------------------------
// tb_maze_path_reducer_top: self-checking bench for the maze path reducer
// Drives move words and replay_mode writes through the handshake channels.
// A behavioural stack model predicts every result word: pushes, dead-end
// folds (cascades included), drops on a full stack and replay walks. Results
// are checked in order against the predicted words. Both sides idle at random,
// except for stretches with no idling at all.
// ----------------------------------------------------------------------------
module tb_maze_path_reducer_top;
	import mrp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_PCT     = 21;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_MOVES = 1600;

	typedef struct packed {
		logic [1:0] move_out;
		logic       move_valid;
		logic [7:0] stored_count;
		logic       dropped;
	} path_word_t;

	logic clk = 1'b0;
	logic arst_n;

	mrp_move_if   moves_ch ();
	mrp_result_if results_ch ();
	mrp_cfg_if    cfg_ch ();

	maze_path_reducer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.moves   (moves_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	// model of the block: stack, fill level, replay position and mode
	logic [1:0] path_stack [CAP];
	int         path_len;
	int         replay_pos;
	logic       replay_sel;

	path_word_t expected_words[$];
	int         mismatches;
	int         moves_sent;
	int         src_idle_pct;
	int         sink_idle_pct;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// report one mismatch and count it
	task automatic report_mismatch(input string msg);
		$display("ERROR %0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	// replacement for the triple first,B,last; returns 0 where no rule applies
	function automatic logic fold_rule(input logic [1:0] first, input logic [1:0] last,
			output logic [1:0] folded);
		logic hit;
		hit    = 1'b1;
		folded = MV_L;
		case (first)
			MV_L: begin
				case (last)
					MV_L:    folded = MV_S;
					MV_S:    folded = MV_R;
					MV_R:    folded = MV_B;
					default: hit = 1'b0;
				endcase
			end
			MV_S: begin
				case (last)
					MV_L:    folded = MV_R;
					MV_S:    folded = MV_B;
					MV_R:    folded = MV_L;
					default: hit = 1'b0;
				endcase
			end
			MV_R: begin
				case (last)
					MV_L:    folded = MV_B;
					MV_S:    folded = MV_L;
					default: hit = 1'b0;
				endcase
			end
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// a random move that folds with the given first move across a back
	function automatic logic [1:0] fold_partner(input logic [1:0] first);
		if (first == MV_R)
			return $urandom_range(0, 1) ? MV_S : MV_L;
		return 2'($urandom_range(0, 2));
	endfunction

	// work out the result word of one accepted move and queue it
	task automatic predict_move(input logic [1:0] mv);
		path_word_t w;
		logic [1:0] folded;
		logic       folding;
		w = '0;
		if (replay_sel) begin
			if (replay_pos < path_len) begin
				w.move_out   = path_stack[replay_pos];
				w.move_valid = 1'b1;
				replay_pos++;
			end
		end else if (path_len + 2 >= CAP) begin
			w.dropped = 1'b1;
		end else begin
			path_stack[path_len] = mv;
			path_len++;
			// fold x,B,y triples until none applies
			folding = 1'b1;
			while (folding) begin
				folding = 1'b0;
				if (path_len >= 3 && path_stack[path_len - 2] == MV_B) begin
					if (fold_rule(path_stack[path_len - 3], path_stack[path_len - 1], folded)) begin
						path_len -= 2;
						path_stack[path_len - 1] = folded;
						folding = 1'b1;
					end
				end
			end
		end
		w.stored_count = 8'(path_len);
		expected_words.push_back(w);
	endtask

	// send one move word; starts and ends at a falling edge, valid left high
	task automatic send_move(input logic [1:0] mv);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			moves_ch.valid <= 1'b0;
			@(negedge clk);
		end
		moves_ch.valid   <= 1'b1;
		moves_ch.move_in <= mv;
		@(posedge clk);
		while (!moves_ch.ready)
			@(posedge clk);
		predict_move(mv);
		moves_sent++;
		@(negedge clk);
	endtask

	// drop valid and wait until every expected word has come back
	task automatic wait_for_idle();
		moves_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	// write replay_mode while the block is idle; any write rewinds replay
	task automatic write_mode(input logic mode);
		wait_for_idle();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.replay_mode <= mode;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		replay_sel = mode;
		replay_pos = 0;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// push a back and a move that folds with the top, close an open triple, or else push a random move
	task automatic send_dead_end();
		if (path_len >= 1 && path_stack[path_len - 1] != MV_B) begin
			send_move(MV_B);
			send_move(fold_partner(path_stack[path_len - 2]));
		end else if (path_len >= 2 && path_stack[path_len - 2] != MV_B) begin
			send_move(fold_partner(path_stack[path_len - 2]));
		end else begin
			send_move(2'($urandom_range(0, 2)));
		end
	endtask

	// every rule, cascades, back after back and triples without a rule
	task automatic test_rule_folds();
		logic [1:0] seq[$];
		seq = '{MV_L, MV_B, MV_R,  MV_S, MV_B, MV_L,  MV_B, MV_L,
			MV_S, MV_B, MV_S,  MV_L, MV_B, MV_L,  MV_B, MV_R,  MV_B, MV_S,
			MV_B, MV_R,  MV_B, MV_S,  MV_L, MV_B, MV_B};
		write_mode(1'b0);
		foreach (seq[i])
			send_move(seq[i]);
	endtask

	// walk the stored moves, rewind mid-way and run past the end
	task automatic test_replay_walk();
		int n;
		write_mode(1'b1);
		repeat (3) send_move(2'($urandom));
		write_mode(1'b1);
		n = path_len + 3;
		repeat (n) send_move(2'($urandom));
		write_mode(1'b0);
	endtask

	// phases of recording and replay with random content
	task automatic test_random_phases();
		int phase;
		int n;
		int pick;
		phase = 0;
		while (moves_sent < RANDOM_MOVES) begin
			// one phase with no idling on either side
			src_idle_pct  = (phase == 3) ? 0 : IDLE_PCT;
			sink_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
			if ($urandom_range(0, 99) < 70) begin
				write_mode(1'b0);
				n = (phase == 3) ? 200 : $urandom_range(10, 60);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 99);
					if (path_len > 90 || pick < 45)
						send_dead_end();
					else if (pick < 85)
						send_move(2'($urandom_range(0, 2)));
					else
						send_move(2'($urandom));
				end
			end else begin
				write_mode(1'b1);
				n = $urandom_range(1, path_len + 3);
				repeat (n) send_move(2'($urandom));
			end
			phase++;
		end
		src_idle_pct  = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;
	endtask

	// fill the stack until pushes drop, replay all of it, then push again
	task automatic test_stack_full();
		int n;
		write_mode(1'b0);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		repeat (CAP) send_move(2'($urandom_range(0, 2)));
		send_move(MV_B);
		send_move(MV_L);
		src_idle_pct  = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;
		write_mode(1'b1);
		n = path_len + 2;
		repeat (n) send_move(2'($urandom));
		write_mode(1'b0);
		send_move(MV_B);
		send_move(MV_S);
	endtask

	// result ready, idling at random
	always @(negedge clk)
		results_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

	// check each result word against the oldest expectation
	always @(posedge clk) begin
		path_word_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("result word with none expected (stored_count %0d)",
					results_ch.stored_count));
			end else begin
				want = expected_words.pop_front();
				if (results_ch.move_out !== want.move_out)
					report_mismatch($sformatf("move_out %0d, expected %0d",
						results_ch.move_out, want.move_out));
				if (results_ch.move_valid !== want.move_valid)
					report_mismatch($sformatf("move_valid %0b, expected %0b",
						results_ch.move_valid, want.move_valid));
				if (results_ch.stored_count !== want.stored_count)
					report_mismatch($sformatf("stored_count %0d, expected %0d",
						results_ch.stored_count, want.stored_count));
				if (results_ch.dropped !== want.dropped)
					report_mismatch($sformatf("dropped %0b, expected %0b",
						results_ch.dropped, want.dropped));
			end
		end
	end

	// end the run when no word moves on any channel for too long
	initial begin
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((moves_ch.valid && moves_ch.ready) || (results_ch.valid && results_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
		$display("tb_maze_path_reducer_top: FAIL");
		$finish;
	end

	// reset, run the tests in turn, drain and report
	initial begin
		arst_n             = 1'b0;
		moves_ch.valid     = 1'b0;
		moves_ch.move_in   = MV_L;
		cfg_ch.valid       = 1'b0;
		cfg_ch.replay_mode = 1'b0;
		results_ch.ready   = 1'b0;
		path_len           = 0;
		replay_pos         = 0;
		replay_sel         = 1'b0;
		mismatches         = 0;
		moves_sent         = 0;
		src_idle_pct       = IDLE_PCT;
		sink_idle_pct      = IDLE_PCT;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_rule_folds();
		test_replay_walk();
		test_random_phases();
		test_stack_full();
		wait_for_idle();

		if (mismatches == 0)
			$display("tb_maze_path_reducer_top: PASS");
		else
			$display("tb_maze_path_reducer_top: FAIL");
		$finish;
	end

endmodule
